// ===== src/tulru_pkg.sv =====
// Shared types, constants and codes for the texture unit binding allocator.
`timescale 1ns / 1ps
`default_nettype none

package tulru_pkg;

  localparam int UNITS    = 16;
  localparam int UNIT_W   = $clog2(UNITS);
  localparam int CNT_W    = $clog2(UNITS + 1);
  localparam int HANDLE_W = 32;
  localparam int MODE_W   = 3;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_AUTO      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_BIND_SEL  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BIND_CUR  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_UNBIND    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SET_ACT   = 3'd4;

  typedef logic [UNIT_W-1:0]   unit_t;
  typedef logic [HANDLE_W-1:0] handle_t;
  typedef unit_t [UNITS-1:0]   order_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_FREE_TGT,
    ST_FREE_OTHER,
    ST_BIND,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_LOOKUP,
    CMD_FREE_TGT,
    CMD_FREE_OTHER,
    CMD_BIND,
    CMD_PUBLISH
  } cmd_e;

  typedef struct packed {
    logic free_tgt;
    logic free_other;
    logic do_bind;
  } plan_t;

  typedef struct packed {
    plan_t plan;
    logic  out_busy;
  } status_t;

endpackage

`default_nettype wire

// ===== src/texture_unit_binding_lru_top.sv =====
// Top level of the texture unit binding allocator: sequencer plus datapath.
//
// Usage:
//   Requests arrive on the input channel (in_valid_i / in_stall_o with mode_i,
//   handle_i, unit_select_i); a transfer happens on a clock edge with valid
//   high and stall low. Each request gives exactly one result transfer on the
//   output channel (out_valid_o / out_stall_i). unit_count is written through
//   cfg_we_i / cfg_wdata_i while the block is idle; it applies to the next request.
// Timing:
//   One request at a time: the parallel handle match and plan (LOOKUP), then
//   each order move in its own state (free old handle, free previous holder,
//   bind and move to back: zero to three of them), then the load of the output
//   register (DONE). Input stall is high from the transfer until the result is
//   loaded into the output register.
// Stall and reset:
//   While the receiver stalls, the result holds in the output register and
//   the next request waits to load. Reset (rst_ni low) clears all bindings,
//   restores ascending recency order, active unit 0 and unit_count 16.
`timescale 1ns / 1ps
`default_nettype none

module texture_unit_binding_lru_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [tulru_pkg::CNT_W-1:0]           cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [tulru_pkg::MODE_W-1:0]          mode_i,
  input  logic [tulru_pkg::HANDLE_W-1:0]        handle_i,
  input  logic [tulru_pkg::UNIT_W-1:0]          unit_select_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [tulru_pkg::UNIT_W-1:0]          unit_out_o,
  output logic                                  hit_o,
  output logic                                  issue_bind_o,
  output logic                                  issue_activate_o,
  output logic                                  error_o,
  output logic [tulru_pkg::UNIT_W-1:0]          active_now_o
);

  tulru_pkg::cmd_e    cmd;
  tulru_pkg::status_t status;

  tulru_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  tulru_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .mode_i           (mode_i),
    .handle_i         (handle_i),
    .unit_select_i    (unit_select_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .unit_out_o       (unit_out_o),
    .hit_o            (hit_o),
    .issue_bind_o     (issue_bind_o),
    .issue_activate_o (issue_activate_o),
    .error_o          (error_o),
    .active_now_o     (active_now_o)
  );

`ifndef NO_ASSERTIONS
  // a rejected request reports nothing else
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> !hit_o && !issue_bind_o && !issue_activate_o)
    else $error("error result carries other flags");

  // a real bind is never also a hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && issue_bind_o |-> !hit_o)
    else $error("bind and hit both set");

  // an input transfer starts the lookup in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> cmd == tulru_pkg::CMD_LOOKUP && in_stall_o)
    else $error("lookup did not follow input transfer");

  // a result is loaded only when the output register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd == tulru_pkg::CMD_PUBLISH |-> !(out_valid_o && out_stall_i))
    else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

// ===== src/tulru_ctrl.sv =====
// Sequencer for the binding allocator: steps each request through lookup and order moves.
`timescale 1ns / 1ps
`default_nettype none

module tulru_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  tulru_pkg::status_t status_i,
  output logic               in_stall_o,
  output tulru_pkg::cmd_e    cmd_o
);

  tulru_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tulru_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tulru_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = tulru_pkg::ST_LOOKUP;
      end
      tulru_pkg::ST_LOOKUP: begin
        priority if (status_i.plan.free_tgt)   state_d = tulru_pkg::ST_FREE_TGT;
        else if (status_i.plan.free_other)     state_d = tulru_pkg::ST_FREE_OTHER;
        else if (status_i.plan.do_bind)        state_d = tulru_pkg::ST_BIND;
        else                                   state_d = tulru_pkg::ST_DONE;
      end
      tulru_pkg::ST_FREE_TGT: begin
        priority if (status_i.plan.free_other) state_d = tulru_pkg::ST_FREE_OTHER;
        else if (status_i.plan.do_bind)        state_d = tulru_pkg::ST_BIND;
        else                                   state_d = tulru_pkg::ST_DONE;
      end
      tulru_pkg::ST_FREE_OTHER: begin
        if (status_i.plan.do_bind) state_d = tulru_pkg::ST_BIND;
        else                       state_d = tulru_pkg::ST_DONE;
      end
      tulru_pkg::ST_BIND: begin
        state_d = tulru_pkg::ST_DONE;
      end
      tulru_pkg::ST_DONE: begin
        if (!status_i.out_busy) state_d = tulru_pkg::ST_IDLE;
      end
      default: state_d = tulru_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = tulru_pkg::CMD_NONE;
    in_stall_o = 1'b1;
    unique case (state_q)
      tulru_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) cmd_o = tulru_pkg::CMD_CAPTURE;
      end
      tulru_pkg::ST_LOOKUP:     cmd_o = tulru_pkg::CMD_LOOKUP;
      tulru_pkg::ST_FREE_TGT:   cmd_o = tulru_pkg::CMD_FREE_TGT;
      tulru_pkg::ST_FREE_OTHER: cmd_o = tulru_pkg::CMD_FREE_OTHER;
      tulru_pkg::ST_BIND:       cmd_o = tulru_pkg::CMD_BIND;
      tulru_pkg::ST_DONE: begin
        if (!status_i.out_busy) cmd_o = tulru_pkg::CMD_PUBLISH;
      end
      default: cmd_o = tulru_pkg::CMD_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/tulru_dp.sv =====
// Datapath of the binding allocator: handle table, recency order, active unit, result register.
`timescale 1ns / 1ps
`default_nettype none

module tulru_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  tulru_pkg::cmd_e                       cmd_i,
  output tulru_pkg::status_t                    status_o,
  input  logic                                  cfg_we_i,
  input  logic [tulru_pkg::CNT_W-1:0]           cfg_wdata_i,
  input  logic [tulru_pkg::MODE_W-1:0]          mode_i,
  input  tulru_pkg::handle_t                    handle_i,
  input  tulru_pkg::unit_t                      unit_select_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output tulru_pkg::unit_t                      unit_out_o,
  output logic                                  hit_o,
  output logic                                  issue_bind_o,
  output logic                                  issue_activate_o,
  output logic                                  error_o,
  output tulru_pkg::unit_t                      active_now_o
);

  function automatic tulru_pkg::unit_t find_pos(tulru_pkg::order_t ord, tulru_pkg::unit_t u);
    tulru_pkg::unit_t pos;
    pos = '0;
    for (int i = 0; i < tulru_pkg::UNITS; i++) begin
      if (ord[i] == u) pos = tulru_pkg::UNIT_W'(i);
    end
    return pos;
  endfunction

  function automatic tulru_pkg::order_t move_front(tulru_pkg::order_t ord, tulru_pkg::unit_t u);
    tulru_pkg::order_t res;
    tulru_pkg::unit_t  pos;
    pos    = find_pos(ord, u);
    res[0] = u;
    for (int i = 1; i < tulru_pkg::UNITS; i++) begin
      if (tulru_pkg::UNIT_W'(i) <= pos) res[i] = ord[i-1];
      else                              res[i] = ord[i];
    end
    return res;
  endfunction

  function automatic tulru_pkg::order_t move_back(tulru_pkg::order_t ord, tulru_pkg::unit_t u);
    tulru_pkg::order_t res;
    tulru_pkg::unit_t  pos;
    pos = find_pos(ord, u);
    res[tulru_pkg::UNITS-1] = u;
    for (int i = 0; i < tulru_pkg::UNITS - 1; i++) begin
      if (tulru_pkg::UNIT_W'(i) >= pos) res[i] = ord[i+1];
      else                              res[i] = ord[i];
    end
    return res;
  endfunction

  // captured request
  logic [tulru_pkg::MODE_W-1:0] mode_q;
  tulru_pkg::handle_t           h_q;
  tulru_pkg::unit_t             sel_q;
  logic [tulru_pkg::CNT_W-1:0]  cnt_q;

  // block state
  tulru_pkg::handle_t bound_q [tulru_pkg::UNITS];
  tulru_pkg::handle_t bound_d [tulru_pkg::UNITS];
  tulru_pkg::order_t  order_q, order_d;
  tulru_pkg::unit_t   cur_q, cur_d;

  // per-item plan and pending result
  tulru_pkg::unit_t tgt_q, tgt_d, other_q;
  tulru_pkg::plan_t plan_q, plan_d;
  tulru_pkg::unit_t res_unit_q, res_unit_d;
  logic res_hit_q, res_hit_d, res_bind_q, res_bind_d;
  logic res_act_q, res_act_d, res_err_q, res_err_d;

  // output register
  logic             out_valid_q;
  tulru_pkg::unit_t out_unit_q, out_act_unit_q;
  logic out_hit_q, out_bind_q, out_act_q, out_err_q;

  // lookup terms
  logic [tulru_pkg::CNT_W-1:0] n_eff;
  logic                        found;
  tulru_pkg::unit_t            fidx, pick, u_req;
  tulru_pkg::handle_t          bu;

  always_comb begin
    if (cnt_q == '0)                                     n_eff = tulru_pkg::CNT_W'(1);
    else if (cnt_q > tulru_pkg::CNT_W'(tulru_pkg::UNITS)) n_eff = tulru_pkg::CNT_W'(tulru_pkg::UNITS);
    else                                                  n_eff = cnt_q;
  end

  // parallel handle match, lowest unit wins
  always_comb begin
    found = 1'b0;
    fidx  = '0;
    for (int i = tulru_pkg::UNITS - 1; i >= 0; i--) begin
      if (h_q != '0 && bound_q[i] == h_q) begin
        found = 1'b1;
        fidx  = tulru_pkg::UNIT_W'(i);
      end
    end
  end

  // first unit in recency order that is in use
  always_comb begin
    pick = order_q[0];
    for (int p = tulru_pkg::UNITS - 1; p >= 0; p--) begin
      if (tulru_pkg::CNT_W'(order_q[p]) < n_eff) pick = order_q[p];
    end
  end

  always_comb begin
    unique case (mode_q)
      tulru_pkg::MODE_AUTO:     u_req = pick;
      tulru_pkg::MODE_BIND_SEL: u_req = sel_q;
      tulru_pkg::MODE_BIND_CUR: u_req = cur_q;
      default:                  u_req = sel_q;
    endcase
    bu = bound_q[u_req];
  end

  // plan for this request
  always_comb begin
    plan_d     = '0;
    tgt_d      = u_req;
    res_unit_d = '0;
    res_hit_d  = 1'b0;
    res_bind_d = 1'b0;
    res_act_d  = 1'b0;
    res_err_d  = 1'b0;
    cur_d      = cur_q;
    unique case (mode_q)
      tulru_pkg::MODE_AUTO: begin
        if (h_q == '0) begin
          res_err_d = 1'b1;
        end else if (found) begin
          res_unit_d = fidx;
          res_hit_d  = 1'b1;
        end else begin
          res_unit_d      = u_req;
          res_act_d       = (cur_q != u_req);
          cur_d           = u_req;
          res_bind_d      = 1'b1;
          plan_d.free_tgt = (bu != '0);
          plan_d.do_bind  = 1'b1;
        end
      end
      tulru_pkg::MODE_BIND_SEL, tulru_pkg::MODE_BIND_CUR: begin
        if (h_q == '0 || tulru_pkg::CNT_W'(u_req) >= n_eff) begin
          res_err_d = 1'b1;
        end else begin
          res_unit_d = u_req;
          res_act_d  = (cur_q != u_req);
          cur_d      = u_req;
          if (bu == h_q) begin
            res_hit_d = 1'b1;
          end else begin
            res_bind_d        = 1'b1;
            plan_d.free_tgt   = (bu != '0);
            plan_d.free_other = found;
            plan_d.do_bind    = 1'b1;
          end
        end
      end
      tulru_pkg::MODE_UNBIND: begin
        tgt_d = fidx;
        if (found) begin
          res_unit_d      = fidx;
          res_hit_d       = 1'b1;
          plan_d.free_tgt = 1'b1;
        end
      end
      tulru_pkg::MODE_SET_ACT: begin
        if (tulru_pkg::CNT_W'(sel_q) >= n_eff) begin
          res_err_d = 1'b1;
        end else begin
          res_unit_d = sel_q;
          res_act_d  = (cur_q != sel_q);
          cur_d      = sel_q;
        end
      end
      default: res_err_d = 1'b1;
    endcase
  end

  // table and order updates
  always_comb begin
    bound_d = bound_q;
    order_d = order_q;
    unique case (cmd_i)
      tulru_pkg::CMD_FREE_TGT: begin
        bound_d[tgt_q] = '0;
        order_d        = move_front(order_q, tgt_q);
      end
      tulru_pkg::CMD_FREE_OTHER: begin
        bound_d[other_q] = '0;
        order_d          = move_front(order_q, other_q);
      end
      tulru_pkg::CMD_BIND: begin
        bound_d[tgt_q] = h_q;
        order_d        = move_back(order_q, tgt_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= tulru_pkg::CNT_W'(tulru_pkg::UNITS);
      cur_q       <= '0;
      plan_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < tulru_pkg::UNITS; i++) begin
        bound_q[i] <= '0;
        order_q[i] <= tulru_pkg::UNIT_W'(i);
      end
    end else begin
      if (cfg_we_i) cnt_q <= cfg_wdata_i;
      bound_q <= bound_d;
      order_q <= order_d;
      if (cmd_i == tulru_pkg::CMD_LOOKUP) begin
        cur_q  <= cur_d;
        plan_q <= plan_d;
      end
      if (cmd_i == tulru_pkg::CMD_PUBLISH)   out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i)  out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == tulru_pkg::CMD_CAPTURE) begin
      mode_q <= mode_i;
      h_q    <= handle_i;
      sel_q  <= unit_select_i;
    end
    if (cmd_i == tulru_pkg::CMD_LOOKUP) begin
      tgt_q      <= tgt_d;
      other_q    <= fidx;
      res_unit_q <= res_unit_d;
      res_hit_q  <= res_hit_d;
      res_bind_q <= res_bind_d;
      res_act_q  <= res_act_d;
      res_err_q  <= res_err_d;
    end
    if (cmd_i == tulru_pkg::CMD_PUBLISH) begin
      out_unit_q     <= res_unit_q;
      out_hit_q      <= res_hit_q;
      out_bind_q     <= res_bind_q;
      out_act_q      <= res_act_q;
      out_err_q      <= res_err_q;
      out_act_unit_q <= cur_q;
    end
  end

  always_comb begin
    status_o.plan     = (cmd_i == tulru_pkg::CMD_LOOKUP) ? plan_d : plan_q;
    status_o.out_busy = out_valid_q && out_stall_i;
  end

  assign out_valid_o      = out_valid_q;
  assign unit_out_o       = out_unit_q;
  assign hit_o            = out_hit_q;
  assign issue_bind_o     = out_bind_q;
  assign issue_activate_o = out_act_q;
  assign error_o          = out_err_q;
  assign active_now_o     = out_act_unit_q;

endmodule

`default_nettype wire

// ===== tb/tulru_binding_checker.sv =====
// Checker for the texture unit binding allocator: predicts each result and compares it.
`timescale 1ns / 1ps

module tulru_binding_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tulru_pkg::CNT_W-1:0]      cfg_wdata_i,
  input  logic                             in_valid_i,
  input  logic                             in_stall_o,
  input  logic [tulru_pkg::MODE_W-1:0]     mode_i,
  input  logic [tulru_pkg::HANDLE_W-1:0]   handle_i,
  input  logic [tulru_pkg::UNIT_W-1:0]     unit_select_i,
  input  logic                             out_valid_o,
  input  logic                             out_stall_i,
  input  logic [tulru_pkg::UNIT_W-1:0]     unit_out_o,
  input  logic                             hit_o,
  input  logic                             issue_bind_o,
  input  logic                             issue_activate_o,
  input  logic                             error_o,
  input  logic [tulru_pkg::UNIT_W-1:0]     active_now_o,
  output int unsigned                      fail_count_o,
  output int unsigned                      pending_o
);

  import tulru_pkg::*;

  typedef struct packed {
    unit_t unit;
    logic  hit;
    logic  issue;
    logic  act;
    logic  err;
    unit_t active;
  } binding_result_t;

  // Shadow copy of the allocator state
  handle_t          unit_handle [UNITS];
  unit_t            recency     [UNITS];
  unit_t            shadow_cur;
  logic [CNT_W-1:0] unit_count;

  binding_result_t  binding_results_q [$];
  binding_result_t  want;
  int unsigned      fails;

  function automatic void clear_bindings();
    int i;
    for (i = 0; i < UNITS; i++) begin
      unit_handle[i] = '0;
      recency[i]     = unit_t'(i);
    end
    shadow_cur = '0;
    unit_count = CNT_W'(UNITS);
  endfunction

  function automatic int units_in_use();
    int n;
    n = int'(unit_count);
    if (n < 1) n = 1;
    if (n > UNITS) n = UNITS;
    return n;
  endfunction

  // UNITS when the handle is zero or held nowhere
  function automatic int holder_of(handle_t h);
    int i;
    int u;
    u = UNITS;
    if (h != '0) begin
      for (i = UNITS - 1; i >= 0; i--) if (unit_handle[i] == h) u = i;
    end
    return u;
  endfunction

  function automatic int rank_of(unit_t u);
    int i;
    int p;
    p = 0;
    for (i = 0; i < UNITS; i++) if (recency[i] == u) p = i;
    return p;
  endfunction

  function automatic void release_unit(unit_t u);
    int i;
    unit_handle[u] = '0;
    for (i = rank_of(u); i > 0; i--) recency[i] = recency[i-1];
    recency[0] = u;
  endfunction

  // Returns 1 when a real bind has to be issued
  function automatic logic attach_handle(unit_t u, handle_t h);
    int i;
    int other;
    if (unit_handle[u] == h) return 1'b0;
    if (unit_handle[u] != '0) release_unit(u);
    other = holder_of(h);
    if (other < UNITS) release_unit(unit_t'(other));
    unit_handle[u] = h;
    for (i = rank_of(u); i < UNITS - 1; i++) recency[i] = recency[i+1];
    recency[UNITS-1] = u;
    return 1'b1;
  endfunction

  function automatic binding_result_t resolve_request(logic [MODE_W-1:0] mode, handle_t h,
                                                      unit_t sel);
    binding_result_t r;
    int n;
    int u;
    int p;
    logic found;
    r     = '0;
    n     = units_in_use();
    found = 1'b0;
    case (mode)
      MODE_AUTO: begin
        if (h == '0) begin
          r.err = 1'b1;
        end else begin
          u = holder_of(h);
          if (u < UNITS) begin
            r.unit = unit_t'(u);
            r.hit  = 1'b1;
          end else begin
            // first unit in recency order that is still in use
            u = recency[0];
            for (p = 0; p < UNITS; p++) begin
              if (!found && recency[p] < n) begin
                u     = recency[p];
                found = 1'b1;
              end
            end
            if (shadow_cur != unit_t'(u)) begin
              shadow_cur = unit_t'(u);
              r.act      = 1'b1;
            end
            r.issue = attach_handle(unit_t'(u), h);
            r.unit  = unit_t'(u);
          end
        end
      end
      MODE_BIND_SEL, MODE_BIND_CUR: begin
        u = (mode == MODE_BIND_SEL) ? int'(sel) : int'(shadow_cur);
        if (h == '0 || u >= n) begin
          r.err = 1'b1;
        end else begin
          if (shadow_cur != unit_t'(u)) begin
            shadow_cur = unit_t'(u);
            r.act      = 1'b1;
          end
          r.issue = attach_handle(unit_t'(u), h);
          r.hit   = !r.issue;
          r.unit  = unit_t'(u);
        end
      end
      MODE_UNBIND: begin
        u = holder_of(h);
        if (u < UNITS) begin
          r.unit = unit_t'(u);
          r.hit  = 1'b1;
          release_unit(unit_t'(u));
        end
      end
      MODE_SET_ACT: begin
        if (int'(sel) >= n) begin
          r.err = 1'b1;
        end else begin
          if (shadow_cur != sel) begin
            shadow_cur = sel;
            r.act      = 1'b1;
          end
          r.unit = sel;
        end
      end
      default: r.err = 1'b1;
    endcase
    r.active = shadow_cur;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (act_val !== exp_val) begin
      fails++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_bindings();
      binding_results_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // retire before accepting: a result never leaves on its own request's edge
      if (out_valid_o && !out_stall_i) begin
        if (binding_results_q.size() == 0) begin
          fails++;
          $display("%0t ns: result transfer with nothing expected, unit_out %0d",
                   $time, unit_out_o);
        end else begin
          want = binding_results_q.pop_front();
          check_field("unit_out", 32'(want.unit), 32'(unit_out_o));
          check_field("hit", 32'(want.hit), 32'(hit_o));
          check_field("issue_bind", 32'(want.issue), 32'(issue_bind_o));
          check_field("issue_activate", 32'(want.act), 32'(issue_activate_o));
          check_field("error", 32'(want.err), 32'(error_o));
          check_field("active_now", 32'(want.active), 32'(active_now_o));
        end
      end
      if (cfg_we_i) unit_count = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) begin
        binding_results_q.push_back(resolve_request(mode_i, handle_i, unit_select_i));
      end
      fail_count_o <= fails;
      pending_o    <= binding_results_q.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the texture unit binding allocator: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb_top;

  import tulru_pkg::*;

  // Reserved mode codes, all rejected by the block
  localparam logic [MODE_W-1:0] MODE_UNUSED_FIRST = MODE_SET_ACT + 1'b1;
  localparam logic [MODE_W-1:0] MODE_UNUSED_LAST  = '1;

  localparam int POOL_SIZE    = 24;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 185;
  localparam int BURST_ITEMS  = 40;
  localparam int SETTLE       = 8;
  localparam int STALL_LIMIT  = 1000; // cycles without any transfer

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CNT_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [MODE_W-1:0]    mode_i;
  handle_t              handle_i;
  unit_t                unit_select_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  unit_t                unit_out_o;
  logic                 hit_o;
  logic                 issue_bind_o;
  logic                 issue_activate_o;
  logic                 error_o;
  unit_t                active_now_o;

  int unsigned          fail_count;
  int unsigned          pending;

  // burst: both sides run without gaps or stalls
  logic                 burst;
  int                   rx_wait;
  int unsigned          quiet_cycles;
  handle_t              handle_pool [POOL_SIZE];
  logic [CNT_W-1:0]     phase_counts [PHASES];

  texture_unit_binding_lru_top i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .handle_i         (handle_i),
    .unit_select_i    (unit_select_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .unit_out_o       (unit_out_o),
    .hit_o            (hit_o),
    .issue_bind_o     (issue_bind_o),
    .issue_activate_o (issue_activate_o),
    .error_o          (error_o),
    .active_now_o     (active_now_o)
  );

  tulru_binding_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .handle_i         (handle_i),
    .unit_select_i    (unit_select_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .unit_out_o       (unit_out_o),
    .hit_o            (hit_o),
    .issue_bind_o     (issue_bind_o),
    .issue_activate_o (issue_activate_o),
    .error_o          (error_o),
    .active_now_o     (active_now_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: after each transfer draw a random wait (zero in a burst) and hold stall while it counts down.
  // Counting only while valid is up makes the stall land on a waiting result.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      rx_wait = burst ? 0 : $urandom_range(0, 3);
    end else if (out_valid_o && rx_wait != 0) begin
      rx_wait = rx_wait - 1;
    end
    out_stall_i <= (rx_wait != 0);
  end

  // Watchdog: a hang shows up as a long run of cycles with no transfer at all
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Present one request and hold it until the transfer. The gap to the next
  // request is drawn here; with a zero gap valid simply stays up and the next
  // call replaces the payload in the same step, so valid is never toggled twice.
  task automatic send_request(logic [MODE_W-1:0] mode, handle_t h, unit_t sel);
    int gap;
    in_valid_i    <= 1'b1;
    mode_i        <= mode;
    handle_i      <= h;
    unit_select_i <= sel;
    do @(posedge clk_i); while (in_stall_o);
    gap = burst ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid and let every outstanding result drain. The extra edge before
  // looking at pending lets the checker count a request taken on this edge.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_unit_count(logic [CNT_W-1:0] count);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= count;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly the legal modes on a small set of handles, so hits, rebinding,
  // eviction of the previous holder and unbinds keep happening; a few zero
  // handles, fully random handles and reserved modes on top.
  task automatic random_request();
    int pick;
    logic [MODE_W-1:0] mode;
    handle_t h;
    pick = $urandom_range(0, 99);
    if (pick < 35)      mode = MODE_AUTO;
    else if (pick < 55) mode = MODE_BIND_SEL;
    else if (pick < 65) mode = MODE_BIND_CUR;
    else if (pick < 80) mode = MODE_UNBIND;
    else if (pick < 95) mode = MODE_SET_ACT;
    else mode = MODE_W'($urandom_range(int'(MODE_UNUSED_FIRST), int'(MODE_UNUSED_LAST)));
    pick = $urandom_range(0, 99);
    if (pick < 3)       h = '0;
    else if (pick < 10) h = $urandom;
    else                h = handle_pool[$urandom_range(0, POOL_SIZE - 1)];
    send_request(mode, h, unit_t'($urandom_range(0, UNITS - 1)));
  endtask

  initial begin
    int ph;
    int k;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    mode_i        = MODE_AUTO;
    handle_i      = '0;
    unit_select_i = '0;
    out_stall_i   = 1'b0;
    burst         = 1'b0;
    rx_wait       = 0;
    quiet_cycles  = 0;

    // Small handles collide often; random wide ones toggle the upper bits
    for (k = 0; k < POOL_SIZE; k++) begin
      handle_pool[k] = (k < 12) ? handle_t'(k + 1) : handle_t'($urandom);
    end
    handle_pool[POOL_SIZE-1] = '1;

    // Count settings per phase: extremes, clamped values and one random pick
    phase_counts = '{5'd31, 5'd1, 5'd0, 5'd16, 5'd3, 5'd17, 5'd8, 5'd2, 5'd0, 5'd16};
    phase_counts[8] = CNT_W'($urandom_range(0, 31));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset count of 16 units
    send_request(MODE_AUTO, '0, '0);                      // zero handle rejected
    send_request(MODE_UNUSED_FIRST, 32'h0000_0011, '0);   // reserved modes
    send_request(MODE_UNUSED_FIRST + 1'b1, 32'h0000_0011, '0);
    send_request(MODE_UNUSED_LAST, 32'h0000_0011, '1);
    send_request(MODE_AUTO, 32'h0000_0001, '0);           // miss, takes front unit
    send_request(MODE_AUTO, 32'h0000_0001, '0);           // hit, order untouched
    send_request(MODE_AUTO, '1, '0);                      // miss, next unit, activates
    send_request(MODE_BIND_SEL, 32'h0000_0001, '1);       // moves handle, frees old holder
    send_request(MODE_BIND_SEL, 32'h0000_0001, '1);       // already there
    send_request(MODE_BIND_CUR, 32'hA5A5_A5A5, '0);       // replaces handle on active unit
    send_request(MODE_BIND_SEL, '0, 4'd3);                // zero handle rejected
    send_request(MODE_UNBIND, '0, '0);                    // nothing to unbind
    send_request(MODE_UNBIND, 32'h1234_5678, '0);         // unbound handle
    send_request(MODE_UNBIND, 32'hA5A5_A5A5, '0);         // found and freed
    send_request(MODE_BIND_SEL, 32'h0000_0055, 4'd14);
    send_request(MODE_SET_ACT, '0, 4'd12);
    send_request(MODE_SET_ACT, '0, 4'd12);                // no change, no activate

    // Fewer units: active unit and a bound unit now sit above the count
    write_unit_count(5'd4);
    send_request(MODE_BIND_CUR, 32'h0000_0077, '0);       // active unit out of range
    send_request(MODE_SET_ACT, '0, 4'd9);                 // out of range
    send_request(MODE_AUTO, 32'h0000_0055, '0);           // hit on a unit above the count
    send_request(MODE_BIND_SEL, 32'h0000_0066, 4'd4);     // first unit out of range
    send_request(MODE_BIND_SEL, 32'h5A5A_5A5A, 4'd3);     // last unit in range
    send_request(MODE_AUTO, 32'h0F0F_0F0F, '0);           // miss skips units above count
    send_request(MODE_SET_ACT, '0, '0);

    // Random phases, each at its own unit count; every other phase opens
    // with a stretch where neither side idles
    for (ph = 0; ph < PHASES; ph++) begin
      write_unit_count(phase_counts[ph]);
      burst <= (ph % 2 == 0);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (k == BURST_ITEMS) burst <= 1'b0;
        random_request();
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/tulru_pkg.sv
src/tulru_ctrl.sv
src/tulru_dp.sv
src/texture_unit_binding_lru_top.sv
tb/tulru_binding_checker.sv
tb/tb_top.sv
